>>> rtl/vgd_pkg.sv
`timescale 1ns / 1ps
// Package for the voxel grid dilation block: sizes, codes and row helpers.
// No dependencies; used by every other file.
package vgd_pkg;

  localparam int GRID_DIM = 32;
  localparam int CX_W     = 5;
  localparam int SIZE_W   = 6;
  localparam int ROW_AW   = 2 * CX_W;
  localparam int ROW_CW   = 2 * GRID_DIM;
  localparam int REACH    = 7;
  localparam int REACH_W  = 3;
  localparam int SQ_W     = 2 * REACH_W;
  localparam int WGT_W    = 32;
  localparam int PROD_W   = SQ_W + WGT_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int TAB_AW   = 2 * REACH_W;
  localparam logic [SUM_W-1:0] ONE_Q24 = SUM_W'(64'd1 << 24);

  // input beat function codes
  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_INFLATE = 2'd1;
  localparam logic [1:0] FUNC_READ    = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_SIZE_X   = 3'd0;
  localparam logic [2:0] CFG_SIZE_Y   = 3'd1;
  localparam logic [2:0] CFG_SIZE_Z   = 3'd2;
  localparam logic [2:0] CFG_BOX      = 3'd3;
  localparam logic [2:0] CFG_WEIGHT_X = 3'd4;
  localparam logic [2:0] CFG_WEIGHT_Y = 3'd5;
  localparam logic [2:0] CFG_WEIGHT_Z = 3'd6;

  // span table entry: valid flag and largest |dx|
  typedef struct packed {
    logic                 ok;
    logic [REACH_W-1:0]   span;
  } span_ent_t;

  // clip a size register to the grid dimension
  function automatic logic [SIZE_W-1:0] clip_size(input logic [SIZE_W-1:0] s);
    clip_size = (s > SIZE_W'(GRID_DIM)) ? SIZE_W'(GRID_DIM) : s;
  endfunction

  // mask of cells x < n
  function automatic logic [GRID_DIM-1:0] use_mask(input logic [SIZE_W-1:0] n);
    logic [GRID_DIM-1:0] m;
    m = '0;
    for (int x = 0; x < GRID_DIM; x++) begin
      m[x] = (SIZE_W'(x) < n);
    end
    use_mask = m;
  endfunction

  // spread each seed bit by +/- s along the row
  function automatic logic [GRID_DIM-1:0] dilate_row(input logic [GRID_DIM-1:0] seeds,
                                                      input logic [REACH_W-1:0] s);
    logic [GRID_DIM-1:0] r;
    r = '0;
    for (int x = 0; x < GRID_DIM; x++) begin
      for (int d = 0; d <= REACH; d++) begin
        if (REACH_W'(d) <= s) begin
          if (x - d >= 0 && seeds[x-d]) r[x] = 1'b1;
          if (x + d < GRID_DIM && seeds[x+d]) r[x] = 1'b1;
        end
      end
    end
    dilate_row = r;
  endfunction

endpackage

>>> rtl/vgd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command beats and result beats.
// Depends on vgd_pkg for field widths.
interface vgd_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic [vgd_pkg::CX_W-1:0]  cell_x;
  logic [vgd_pkg::CX_W-1:0]  cell_y;
  logic [vgd_pkg::CX_W-1:0]  cell_z;
  logic                      occupied_in;
  modport source (output valid, func, cell_x, cell_y, cell_z, occupied_in, input ready);
  modport sink   (input valid, func, cell_x, cell_y, cell_z, occupied_in, output ready);
endinterface

interface vgd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] cell_code;
  modport source (output valid, cell_code, input ready);
  modport sink   (input valid, cell_code, output ready);
endinterface

>>> rtl/vgd_span.sv
`timescale 1ns / 1ps
// Ellipsoid span table: for each |dy|,|dz| the largest |dx| inside the ellipsoid.
// A squarer and one shared multiplier under a small sequencer; depends on vgd_pkg.
module vgd_span (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [vgd_pkg::WGT_W-1:0]           weight_x,
  input  logic [vgd_pkg::WGT_W-1:0]           weight_y,
  input  logic [vgd_pkg::WGT_W-1:0]           weight_z,
  input  logic [vgd_pkg::TAB_AW-1:0]          rd_addr,
  output vgd_pkg::span_ent_t                  rd_data,
  output logic                                done
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MY   = 2'd1;
  localparam logic [1:0] S_AY   = 2'd2;
  localparam logic [1:0] S_CX   = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [vgd_pkg::REACH_W-1:0]   a_r, a_nxt, b_r, b_nxt, dx_r, dx_nxt;
  logic                          az_r, az_nxt;
  logic                          done_r, done_nxt;
  logic [vgd_pkg::PROD_W-1:0]    prod_r;
  logic [vgd_pkg::SUM_W-1:0]     base_r;
  logic [vgd_pkg::REACH_W-1:0]   sq_in;
  logic [vgd_pkg::SQ_W-1:0]      sq;
  logic [vgd_pkg::WGT_W-1:0]     mw;
  logic [vgd_pkg::SUM_W-1:0]     total;
  logic                          tab_we;
  vgd_pkg::span_ent_t            tab_wdata;
  vgd_pkg::span_ent_t            tab_mem [2**vgd_pkg::TAB_AW];
  vgd_pkg::span_ent_t            rd_q_r;

  assign total = base_r + vgd_pkg::SUM_W'(prod_r);
  assign sq    = vgd_pkg::SQ_W'(sq_in) * vgd_pkg::SQ_W'(sq_in);

  // select multiplier operands for the current step
  always_comb begin
    sq_in = a_r;
    mw    = weight_y;
    case (state_r)
      S_MY: begin
        sq_in = a_r;
        mw    = weight_y;
      end
      S_AY: begin
        sq_in = az_r ? vgd_pkg::REACH_W'(vgd_pkg::REACH) : b_r;
        mw    = az_r ? weight_x : weight_z;
      end
      S_CX: begin
        sq_in = dx_r - 1'b1;
        mw    = weight_x;
      end
      default: begin
        sq_in = a_r;
        mw    = weight_y;
      end
    endcase
  end

  // sequence: y term, z term, then walk dx down until inside or dx reaches zero
  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    dx_nxt    = dx_r;
    az_nxt    = az_r;
    done_nxt  = done_r;
    tab_we    = 1'b0;
    tab_wdata = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          a_nxt     = '0;
          b_nxt     = '0;
          done_nxt  = 1'b0;
          state_nxt = S_MY;
        end
      end
      S_MY: begin
        az_nxt    = 1'b0;
        state_nxt = S_AY;
      end
      S_AY: begin
        if (az_r) begin
          dx_nxt    = vgd_pkg::REACH_W'(vgd_pkg::REACH);
          state_nxt = S_CX;
        end
        az_nxt = 1'b1;
      end
      S_CX: begin
        if (total <= vgd_pkg::ONE_Q24 || dx_r == '0) begin
          tab_we         = 1'b1;
          tab_wdata.ok   = (total <= vgd_pkg::ONE_Q24);
          tab_wdata.span = dx_r;
          if (a_r == vgd_pkg::REACH_W'(vgd_pkg::REACH) &&
              b_r == vgd_pkg::REACH_W'(vgd_pkg::REACH)) begin
            done_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            if (b_r == vgd_pkg::REACH_W'(vgd_pkg::REACH)) begin
              b_nxt = '0;
              a_nxt = a_r + 1'b1;
            end else begin
              b_nxt = b_r + 1'b1;
            end
            state_nxt = S_MY;
          end
        end else begin
          dx_nxt = dx_r - 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    dx_r   <= dx_nxt;
    az_r   <= az_nxt;
    // one product per cycle, registered
    prod_r <= vgd_pkg::PROD_W'(sq) * vgd_pkg::PROD_W'(mw);
    // accumulate the y and z terms
    if (state_r == S_AY) begin
      base_r <= az_r ? total : vgd_pkg::SUM_W'(prod_r);
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[{a_r, b_r}] <= tab_wdata;
    rd_q_r <= tab_mem[rd_addr];
  end

  assign rd_data = rd_q_r;
  assign done    = done_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == S_IDLE)) else $error("span done while busy");
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (start && state_r == S_IDLE) |=> !done_r) else $error("span done not cleared");
  a_dx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CX && total > vgd_pkg::ONE_Q24 && dx_r != '0) |=> (dx_r == $past(dx_r) - 1'b1))
    else $error("dx walk broken");

endmodule

>>> rtl/voxel_grid_dilation.sv
`timescale 1ns / 1ps
// Voxel grid dilation top level: 32x32x32 grid of 2-bit codes in a row memory.
// Write and read beats go through ST_CRD, ST_CELL (read result registered, held
// until taken). Inflate snapshots the seeds of every row, waits for the span table,
// then sweeps the rows, skipping unused ones and scanning all dy,dz offsets within
// +/-R for in-use ones, R = box_reach or 7 in ellipsoid mode; input is not ready
// meanwhile. Sync reset; then a 1024-row pass clears the grid before the first beat.
// Depends on vgd_pkg, vgd_if and vgd_span.
module voxel_grid_dilation (
  input  logic                          clk,
  input  logic                          rst_n,
  vgd_in_if.sink                        in_ch,
  vgd_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [vgd_pkg::WGT_W-1:0]     cfg_wdata
);

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_CRD     = 4'd2;
  localparam logic [3:0] ST_CELL    = 4'd3;
  localparam logic [3:0] ST_SNAP_RD = 4'd4;
  localparam logic [3:0] ST_SNAP_WR = 4'd5;
  localparam logic [3:0] ST_WAIT    = 4'd6;
  localparam logic [3:0] ST_ROW     = 4'd7;
  localparam logic [3:0] ST_SCAN    = 4'd8;
  localparam logic [3:0] ST_DRAIN   = 4'd9;
  localparam logic [3:0] ST_UPD     = 4'd10;

  localparam int GD  = vgd_pkg::GRID_DIM;
  localparam int RW  = vgd_pkg::REACH_W;

  // configuration registers
  logic [vgd_pkg::SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [RW-1:0]              box_r;
  logic [vgd_pkg::WGT_W-1:0]  wx_r, wy_r, wz_r;

  logic [3:0]                 state_r, state_nxt;
  logic [1:0]                 func_r;
  logic [vgd_pkg::CX_W-1:0]   cx_r, cy_r, cz_r;
  logic                       occ_r;
  logic [vgd_pkg::ROW_AW-1:0] row_r, row_nxt;
  logic signed [RW:0]         dy_r, dy_nxt, dz_r, dz_nxt;
  logic                       pv_r, pv_nxt;
  logic [GD-1:0]              hit_r;
  logic                       out_valid_r;
  logic [1:0]                 out_code_r;

  logic [vgd_pkg::SIZE_W-1:0] nx, ny, nz;
  logic [GD-1:0]              xmask;
  logic                       accept, cell_in_use, row_use, span_done, span_start;
  logic [RW-1:0]              rr;
  logic signed [RW:0]         rr_s;
  logic signed [vgd_pkg::SIZE_W:0] jy, jz;
  logic                       nb_ok;
  logic [RW-1:0]              ady, adz;
  vgd_pkg::span_ent_t         span_q;
  logic                       span_ok;
  logic [RW-1:0]              span_s;

  // grid and seed memories
  logic [vgd_pkg::ROW_CW-1:0] grid_mem [2**vgd_pkg::ROW_AW];
  logic [GD-1:0]              seed_mem [2**vgd_pkg::ROW_AW];
  logic [vgd_pkg::ROW_CW-1:0] grid_q_r, g_wdata;
  logic [vgd_pkg::ROW_AW-1:0] g_addr, s_raddr;
  logic                       g_we, s_we;
  logic [GD-1:0]              s_wdata, seed_q_r, code_nz, new_mark;
  logic                       set_out;
  logic [1:0]                 set_code;

  assign nx     = vgd_pkg::clip_size(size_x_r);
  assign ny     = vgd_pkg::clip_size(size_y_r);
  assign nz     = vgd_pkg::clip_size(size_z_r);
  assign xmask  = vgd_pkg::use_mask(nx);
  assign accept = in_ch.valid && in_ch.ready;
  assign cell_in_use = ({1'b0, in_ch.cell_x} < nx) && ({1'b0, in_ch.cell_y} < ny) &&
                       ({1'b0, in_ch.cell_z} < nz);
  assign row_use = ({1'b0, row_r[vgd_pkg::CX_W-1:0]} < ny) &&
                   ({1'b0, row_r[vgd_pkg::ROW_AW-1:vgd_pkg::CX_W]} < nz);
  assign rr     = (box_r != '0) ? box_r : RW'(vgd_pkg::REACH);
  assign rr_s   = $signed({1'b0, rr});

  // neighbor row for the current offset
  assign jy    = $signed({2'b00, row_r[vgd_pkg::CX_W-1:0]}) + (vgd_pkg::SIZE_W+1)'(dy_r);
  assign jz    = $signed({2'b00, row_r[vgd_pkg::ROW_AW-1:vgd_pkg::CX_W]}) +
                 (vgd_pkg::SIZE_W+1)'(dz_r);
  assign nb_ok = (jy >= 0) && (jy < $signed({1'b0, ny})) &&
                 (jz >= 0) && (jz < $signed({1'b0, nz}));
  assign ady   = RW'((dy_r < 0) ? -dy_r : dy_r);
  assign adz   = RW'((dz_r < 0) ? -dz_r : dz_r);
  assign s_raddr = {jz[vgd_pkg::CX_W-1:0], jy[vgd_pkg::CX_W-1:0]};

  // span for the offset in flight: box uses the reach, ellipsoid the table
  assign span_ok = (box_r != '0) ? 1'b1 : span_q.ok;
  assign span_s  = (box_r != '0) ? box_r : span_q.span;

  always_comb begin
    for (int x = 0; x < GD; x++) begin
      code_nz[x]  = (grid_q_r[2*x +: 2] != 2'd0);
    end
  end
  assign new_mark = hit_r & xmask & ~code_nz;

  vgd_span u_span (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (span_start),
    .weight_x (wx_r),
    .weight_y (wy_r),
    .weight_z (wz_r),
    .rd_addr  ({ady, adz}),
    .rd_data  (span_q),
    .done     (span_done)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    dy_nxt     = dy_r;
    dz_nxt     = dz_r;
    pv_nxt     = 1'b0;
    g_we       = 1'b0;
    g_addr     = row_r;
    g_wdata    = '0;
    s_we       = 1'b0;
    s_wdata    = '0;
    span_start = 1'b0;
    set_out    = 1'b0;
    set_code   = 2'd0;
    case (state_r)
      ST_CLEAR: begin
        g_we    = 1'b1;
        row_nxt = row_r + 1'b1;
        if (row_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.func)
            vgd_pkg::FUNC_WRITE: if (cell_in_use) state_nxt = ST_CRD;
            vgd_pkg::FUNC_READ: begin
              if (cell_in_use) state_nxt = ST_CRD;
              else set_out = 1'b1;
            end
            vgd_pkg::FUNC_INFLATE: begin
              span_start = 1'b1;
              row_nxt    = '0;
              state_nxt  = ST_SNAP_RD;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CRD: begin
        g_addr    = {cz_r, cy_r};
        state_nxt = ST_CELL;
      end
      ST_CELL: begin
        g_addr  = {cz_r, cy_r};
        g_wdata = grid_q_r;
        g_wdata[2*cx_r +: 2] = {1'b0, occ_r};
        if (func_r == vgd_pkg::FUNC_WRITE) begin
          g_we = 1'b1;
        end else begin
          set_out  = 1'b1;
          set_code = grid_q_r[2*cx_r +: 2];
        end
        state_nxt = ST_IDLE;
      end
      ST_SNAP_RD: begin
        state_nxt = ST_SNAP_WR;
      end
      ST_SNAP_WR: begin
        s_we    = 1'b1;
        s_wdata = row_use ? (code_nz & xmask) : '0;
        row_nxt = row_r + 1'b1;
        state_nxt = (row_r == '1) ? ST_WAIT : ST_SNAP_RD;
      end
      ST_WAIT: begin
        if (span_done) state_nxt = ST_ROW;
      end
      ST_ROW: begin
        if (row_use) begin
          dy_nxt    = -rr_s;
          dz_nxt    = -rr_s;
          state_nxt = ST_SCAN;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = (row_r == '1) ? ST_IDLE : ST_ROW;
        end
      end
      ST_SCAN: begin
        pv_nxt = nb_ok;
        if (dy_r == rr_s) begin
          dy_nxt = -rr_s;
          dz_nxt = dz_r + 1'b1;
          if (dz_r == rr_s) state_nxt = ST_DRAIN;
        end else begin
          dy_nxt = dy_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        g_we    = 1'b1;
        g_wdata = grid_q_r;
        for (int x = 0; x < GD; x++) begin
          if (new_mark[x]) g_wdata[2*x +: 2] = 2'd2;
        end
        row_nxt   = row_r + 1'b1;
        state_nxt = (row_r == '1) ? ST_IDLE : ST_ROW;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      row_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      size_x_r    <= vgd_pkg::SIZE_W'(vgd_pkg::GRID_DIM);
      size_y_r    <= vgd_pkg::SIZE_W'(vgd_pkg::GRID_DIM);
      size_z_r    <= vgd_pkg::SIZE_W'(vgd_pkg::GRID_DIM);
      box_r       <= RW'(1);
      wx_r        <= '0;
      wy_r        <= '0;
      wz_r        <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      pv_r    <= pv_nxt;
      // hold result until taken
      if (set_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          vgd_pkg::CFG_SIZE_X:   size_x_r <= cfg_wdata[vgd_pkg::SIZE_W-1:0];
          vgd_pkg::CFG_SIZE_Y:   size_y_r <= cfg_wdata[vgd_pkg::SIZE_W-1:0];
          vgd_pkg::CFG_SIZE_Z:   size_z_r <= cfg_wdata[vgd_pkg::SIZE_W-1:0];
          vgd_pkg::CFG_BOX:      box_r    <= cfg_wdata[RW-1:0];
          vgd_pkg::CFG_WEIGHT_X: wx_r     <= cfg_wdata;
          vgd_pkg::CFG_WEIGHT_Y: wy_r     <= cfg_wdata;
          vgd_pkg::CFG_WEIGHT_Z: wz_r     <= cfg_wdata;
          default: ;
        endcase
      end
    end
    dy_r <= dy_nxt;
    dz_r <= dz_nxt;
    if (set_out) out_code_r <= set_code;
    // latch the command beat
    if (accept) begin
      func_r <= in_ch.func;
      cx_r   <= in_ch.cell_x;
      cy_r   <= in_ch.cell_y;
      cz_r   <= in_ch.cell_z;
      occ_r  <= in_ch.occupied_in;
    end
    // accumulate neighbor hits for the current row
    if (state_r == ST_ROW) hit_r <= '0;
    else if (pv_r && span_ok) hit_r <= hit_r | vgd_pkg::dilate_row(seed_q_r, span_s);
  end

  // memories with registered read data
  always_ff @(posedge clk) begin
    if (g_we) grid_mem[g_addr] <= g_wdata;
    grid_q_r <= grid_mem[g_addr];
    if (s_we) seed_mem[row_r] <= s_wdata;
    seed_q_r <= seed_mem[s_raddr];
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.cell_code = out_code_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!out_valid_r && state_r == ST_IDLE)) else $error("ready while busy");
  a_inflate_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.func == vgd_pkg::FUNC_INFLATE) |=> (state_r == ST_SNAP_RD))
    else $error("inflate did not start snapshot");
  a_pv_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == ST_SCAN || state_r == ST_DRAIN)) else $error("stray hit beat");
  a_span_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW) |-> span_done) else $error("sweep before span table");

endmodule
